// File: rtl/core/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared sizes, codes and control structs for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DELTA_BITS = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int DELAY_W    = 32;
  localparam int HANDLE_W   = 16;
  localparam int OCC_W      = 5;

  localparam logic [63:0] DELTA_MAX64 = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - DELTA_BITS);
  localparam logic [DELTA_BITS-1:0] DELTA_MAX = DELTA_MAX64[DELTA_BITS-1:0];

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_POP    = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IDLE    = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_WALK,
    S_INS_FIX,
    S_INS_PUT,
    S_TICK,
    S_POP,
    S_CAN,
    S_MERGE,
    S_DROP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    sub_t;       // walk: t -= delta[idx]
    logic    inc_idx;
    logic    save_d;      // keep delta[idx] for the merge
    logic    grab_woken;
    logic    fix_succ;    // delta[idx] -= t
    logic    ins_shift;   // open a slot at idx and write the new entry
    logic    merge;       // delta[idx] += saved delta, saturating
    logic    drop_shift;  // close the slot at idx-1
    logic    tick_head;
    logic    emit;
    status_t status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  idx_lt_cnt;
    logic  t_ge_rd;
    logic  rd_zero;
    logic  match;
  } sts_t;

endpackage

// File: rtl/core/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for insert, tick, pop and cancel over the delta-list datapath.
// ----------------------------------------------------------------------------
module dltq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dltq_pkg::sts_t  sts,
  output dltq_pkg::cmd_t  cmd,
  output logic            busy
);

  dltq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dltq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != dltq_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dltq_pkg::S_IDLE: begin
        if (start) state_next = dltq_pkg::S_DECODE;
      end
      dltq_pkg::S_DECODE: begin
        unique case (sts.kind)
          dltq_pkg::KIND_INSERT: state_next = dltq_pkg::S_INS_WALK;
          dltq_pkg::KIND_TICK:   state_next = dltq_pkg::S_TICK;
          dltq_pkg::KIND_POP:    state_next = dltq_pkg::S_POP;
          dltq_pkg::KIND_CANCEL: state_next = dltq_pkg::S_CAN;
          default:               state_next = dltq_pkg::S_IDLE;
        endcase
      end
      dltq_pkg::S_INS_WALK: begin
        if (sts.full) state_next = dltq_pkg::S_IDLE;
        else if (!(sts.idx_lt_cnt && sts.t_ge_rd)) state_next = dltq_pkg::S_INS_FIX;
      end
      dltq_pkg::S_INS_FIX: state_next = dltq_pkg::S_INS_PUT;
      dltq_pkg::S_INS_PUT: state_next = dltq_pkg::S_IDLE;
      dltq_pkg::S_TICK:    state_next = dltq_pkg::S_IDLE;
      dltq_pkg::S_POP: begin
        if (sts.empty || !sts.rd_zero) state_next = dltq_pkg::S_IDLE;
        else state_next = dltq_pkg::S_MERGE;
      end
      dltq_pkg::S_CAN: begin
        if (!sts.idx_lt_cnt) state_next = dltq_pkg::S_IDLE;
        else if (sts.match) state_next = dltq_pkg::S_MERGE;
      end
      dltq_pkg::S_MERGE: state_next = dltq_pkg::S_DROP;
      dltq_pkg::S_DROP:  state_next = dltq_pkg::S_IDLE;
      default:           state_next = dltq_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.status = dltq_pkg::ST_DONE;
    unique case (state)
      dltq_pkg::S_IDLE, dltq_pkg::S_DECODE: ;
      dltq_pkg::S_INS_WALK: begin
        if (sts.full) begin
          cmd.emit   = 1'b1;
          cmd.status = dltq_pkg::ST_FULL;
        end else if (sts.idx_lt_cnt && sts.t_ge_rd) begin
          cmd.sub_t   = 1'b1;
          cmd.inc_idx = 1'b1;
        end
      end
      dltq_pkg::S_INS_FIX: cmd.fix_succ = sts.idx_lt_cnt;
      dltq_pkg::S_INS_PUT: begin
        cmd.ins_shift = 1'b1;
        cmd.emit      = 1'b1;
      end
      dltq_pkg::S_TICK: begin
        cmd.emit = 1'b1;
        if (sts.empty) cmd.status = dltq_pkg::ST_IDLE;
        else cmd.tick_head = 1'b1;
      end
      dltq_pkg::S_POP: begin
        if (sts.empty || !sts.rd_zero) begin
          cmd.emit   = 1'b1;
          cmd.status = dltq_pkg::ST_IDLE;
        end else begin
          cmd.grab_woken = 1'b1;
          cmd.save_d     = 1'b1;
          cmd.inc_idx    = 1'b1;
        end
      end
      dltq_pkg::S_CAN: begin
        if (!sts.idx_lt_cnt) begin
          cmd.emit   = 1'b1;
          cmd.status = dltq_pkg::ST_MISSING;
        end else begin
          cmd.inc_idx = 1'b1;
          cmd.save_d  = sts.match;
        end
      end
      dltq_pkg::S_MERGE: cmd.merge = sts.idx_lt_cnt;
      dltq_pkg::S_DROP: begin
        cmd.drop_shift = 1'b1;
        cmd.emit       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/dltq_dpath.sv
// ----------------------------------------------------------------------------
// dltq_dpath
// Entry storage, walk registers and result registers of the timer queue.
// ----------------------------------------------------------------------------
module dltq_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [1:0]                         kind,
  input  logic [dltq_pkg::HANDLE_W-1:0]      waiter,
  input  logic [dltq_pkg::DELAY_W-1:0]       delay,
  input  dltq_pkg::cmd_t                     cmd,
  output dltq_pkg::sts_t                     sts,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [dltq_pkg::HANDLE_W-1:0]      woken,
  output logic [dltq_pkg::OCC_W-1:0]         occupancy
);

  logic [dltq_pkg::HANDLE_W-1:0]   entry_handle [dltq_pkg::CAPACITY];
  logic [dltq_pkg::DELTA_BITS-1:0] entry_delta  [dltq_pkg::CAPACITY];
  logic [dltq_pkg::CNT_W-1:0]      count, count_next;
  logic [dltq_pkg::CNT_W-1:0]      idx;
  logic [dltq_pkg::DELTA_BITS-1:0] t;
  logic [dltq_pkg::DELTA_BITS-1:0] sav;
  logic [dltq_pkg::HANDLE_W-1:0]   h;
  logic [dltq_pkg::HANDLE_W-1:0]   wk;
  dltq_pkg::kind_t                 kind_q;

  logic [dltq_pkg::HANDLE_W-1:0]   rd_h;
  logic [dltq_pkg::DELTA_BITS-1:0] rd_d;
  logic [63:0]                     delay64;
  logic [dltq_pkg::DELTA_BITS-1:0] delay_sat;
  logic [dltq_pkg::DELTA_BITS:0]   sum;
  logic [dltq_pkg::DELTA_BITS-1:0] merged;

  assign rd_h = entry_handle[idx[dltq_pkg::IDX_W-1:0]];
  assign rd_d = entry_delta[idx[dltq_pkg::IDX_W-1:0]];

  assign delay64   = {{(64 - dltq_pkg::DELAY_W){1'b0}}, delay};
  assign delay_sat = (delay64 > dltq_pkg::DELTA_MAX64) ? dltq_pkg::DELTA_MAX
                                                       : delay64[dltq_pkg::DELTA_BITS-1:0];

  assign sum    = {1'b0, rd_d} + {1'b0, sav};
  assign merged = sum[dltq_pkg::DELTA_BITS] ? dltq_pkg::DELTA_MAX
                                            : sum[dltq_pkg::DELTA_BITS-1:0];

  always_comb begin
    count_next = count;
    if (cmd.ins_shift) count_next = count + 1'b1;
    else if (cmd.drop_shift) count_next = count - 1'b1;
  end

  assign sts.kind       = kind_q;
  assign sts.empty      = (count == '0);
  assign sts.full       = (count >= dltq_pkg::CNT_W'(dltq_pkg::CAPACITY));
  assign sts.idx_lt_cnt = (idx < count);
  assign sts.t_ge_rd    = (t >= rd_d);
  assign sts.rd_zero    = (rd_d == '0);
  assign sts.match      = (rd_h == h);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.emit;
    end
  end

  // walk registers and results
  always_ff @(posedge clk) begin
    if (load) begin
      kind_q <= dltq_pkg::kind_t'(kind);
      h      <= waiter;
      t      <= delay_sat;
      idx    <= '0;
      wk     <= '0;
    end else begin
      if (cmd.sub_t) t <= t - rd_d;
      if (cmd.inc_idx) idx <= idx + 1'b1;
    end
    if (cmd.save_d) sav <= rd_d;
    if (cmd.grab_woken) wk <= rd_h;
    if (cmd.emit) begin
      status    <= cmd.status;
      woken     <= wk;
      occupancy <= dltq_pkg::OCC_W'(count_next);
    end
  end

  // entry storage; shifts move each entry past the slot from its fixed neighbor
  always_ff @(posedge clk) begin
    for (int i = 0; i < dltq_pkg::CAPACITY; i++) begin
      if (cmd.ins_shift) begin
        if (dltq_pkg::CNT_W'(i) == idx) begin
          entry_handle[i] <= h;
          entry_delta[i]  <= t;
        end else if (i > 0 && dltq_pkg::CNT_W'(i) > idx) begin
          entry_handle[i] <= entry_handle[(i > 0) ? i - 1 : 0];
          entry_delta[i]  <= entry_delta[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.drop_shift) begin
        if (i + 1 < dltq_pkg::CAPACITY && dltq_pkg::CNT_W'(i + 1) >= idx) begin
          entry_handle[i] <= entry_handle[(i + 1 < dltq_pkg::CAPACITY) ? i + 1 : i];
          entry_delta[i]  <= entry_delta[(i + 1 < dltq_pkg::CAPACITY) ? i + 1 : i];
        end
      end else if (dltq_pkg::CNT_W'(i) == idx) begin
        if (cmd.fix_succ) entry_delta[i] <= rd_d - t;
        else if (cmd.merge) entry_delta[i] <= merged;
        else if (cmd.tick_head) entry_delta[i] <= sts.t_ge_rd ? '0 : rd_d - t;
      end
    end
  end

endmodule

// File: rtl/core/delta_list_timer_queue.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Sorted timer queue held as a delta list: insert, tick, pop and cancel.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind/waiter/delay and raise start; the item is
//   taken on a clock edge with start high and busy low. busy stays high
//   until the item's result has been produced.
//   Result channel: done pulses for one cycle with status, woken and
//   occupancy valid in that cycle. The receiver cannot stall it.
//   Steps after acceptance: a decode state, then for a tick one state;
//   for a pop one check, plus a merge and a drop when the head has
//   expired; for an insert a walk over the entries, a fix and a put
//   (the walk ends at once when the queue is full); for a cancel a walk
//   to the match, then a merge and a drop (a miss ends after the walk).
//   The walk over the entry list, one entry per cycle through the single
//   read port of the entry registers, makes the longest items an insert
//   or a cancel hit past CAPACITY - 1 entries.
//   busy drops in the cycle that done is high, so a waiting item is taken
//   at the edge that ends that cycle.
//   Reset (rst, synchronous) empties the queue; entry contents are not
//   cleared, only the count.
// ----------------------------------------------------------------------------
module delta_list_timer_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [dltq_pkg::HANDLE_W-1:0] waiter,
  input  logic [dltq_pkg::DELAY_W-1:0]  delay,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [dltq_pkg::HANDLE_W-1:0] woken,
  output logic [dltq_pkg::OCC_W-1:0]    occupancy
);

  dltq_pkg::cmd_t cmd;
  dltq_pkg::sts_t sts;
  logic           load;

  // item accepted: latch the command into the datapath
  assign load = start && !busy;

  dltq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dltq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .kind      (kind),
    .waiter    (waiter),
    .delay     (delay),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .status    (status),
    .woken     (woken),
    .occupancy (occupancy)
  );

endmodule
